// ===== design/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the reflection minimum search block.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int RMS_MAX_POINTS = 256;

    localparam int DATA_W   = 32;
    localparam int PROD_W   = 64;
    localparam int IDX_W    = 16;
    localparam int HZ_W     = 33;
    localparam int DB_W     = 17;
    localparam int POS_W    = 8;
    localparam int NUM_W    = 49;
    localparam int LOG_W    = 30;
    localparam int FRAC_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STOP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_POINTS = 2'd2;

    localparam logic [HZ_W-1:0]  START_RESET  = 33'd10000000;
    localparam logic [HZ_W-1:0]  STOP_RESET   = 33'd3000000000;
    localparam logic [IDX_W-1:0] POINTS_RESET = 16'd201;
    localparam logic [HZ_W-1:0]  HZ_MAX       = 33'h1_FFFF_FFFF;

    // 10*log10(2)*256 in Q16
    localparam logic [DATA_W-1:0] DB_CONST = 32'd50504453;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POWER,
        ST_CHECK,
        ST_CMP,
        ST_DECIDE,
        ST_WRAP,
        ST_NORM,
        ST_LOG_MUL,
        ST_LOG_STEP,
        ST_DB_MUL,
        ST_DB_DONE,
        ST_HZ_MUL,
        ST_HZ_DIV,
        ST_HZ_WAIT,
        ST_OUT
    } rms_state_t;

    // k * 10^18 for the small reverse powers where the threshold matters
    function automatic logic [PROD_W-1:0] e18_times(input logic [3:0] k);
        logic [PROD_W-1:0] r;
        unique case (k)
            4'd0: r = 64'd0;
            4'd1: r = 64'd1000000000000000000;
            4'd2: r = 64'd2000000000000000000;
            4'd3: r = 64'd3000000000000000000;
            4'd4: r = 64'd4000000000000000000;
            4'd5: r = 64'd5000000000000000000;
            4'd6: r = 64'd6000000000000000000;
            4'd7: r = 64'd7000000000000000000;
            4'd8: r = 64'd8000000000000000000;
            4'd9: r = 64'd9000000000000000000;
            default: r = '1;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ===== design/rms_mul.sv =====
// ----------------------------------------------------------------------------
// rms_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rms_mul (
    input  logic                       aclk,
    input  logic [rms_pkg::DATA_W-1:0] op_a,
    input  logic [rms_pkg::DATA_W-1:0] op_b,
    output logic [rms_pkg::PROD_W-1:0] product
);
    import rms_pkg::*;

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = product_reg;

endmodule

// ===== design/rms_div.sv =====
// ----------------------------------------------------------------------------
// rms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rms_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rms_pkg::NUM_W-1:0] dividend,
    input  logic [rms_pkg::IDX_W-1:0] divisor,
    output logic                      done,
    output logic [rms_pkg::NUM_W-1:0] quotient,
    output logic [rms_pkg::IDX_W-1:0] remainder
);
    import rms_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] div_reg, div_next;
    logic [IDX_W:0]   trial;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = IDX_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[IDX_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/reflection_minimum_search.sv =====
// ----------------------------------------------------------------------------
// reflection_minimum_search
// Tracks the sweep point with the smallest reflected-to-forward power ratio.
// ----------------------------------------------------------------------------
// One sweep point is taken per transfer; s_tready is high only while the
// sequencer is idle. All arithmetic runs through one shared 32x32 multiplier
// plus a bit-serial divider. Every point passes through the power squares,
// the threshold check and bookkeeping, plus a ratio compare against the held
// minimum (eight partial products) when one is already held. The last point
// adds the result: two normalize passes, 24 squarings per power, the dB
// scale, and a division for the frequency.
// A result waiting on m_tready holds the sequencer in its final state.
module reflection_minimum_search #(
    parameter int MAX_POINTS = rms_pkg::RMS_MAX_POINTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // forward_real, forward_imag, reverse_real, reverse_imag, point_freq_index
    input  logic [143:0]                  s_tdata,
    input  logic                          s_tlast,   // last_point
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // best_position, best_freq_index, best_freq_hz, best_mag_db_q8, zero fill
    output logic [79:0]                   m_tdata,
    output logic                          m_tuser,   // found
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [rms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rms_pkg::HZ_W-1:0]      cfg_wdata
);
    import rms_pkg::*;

    localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int ACC_W = 130;

    rms_state_t state_reg, state_next;

    logic [HZ_W-1:0]   start_reg, stop_reg;
    logic [IDX_W-1:0]  points_reg;

    logic [DATA_W-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [DATA_W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] pf_reg, pf_next, pr_reg, pr_next;
    logic [PROD_W-1:0] best_rev_reg, best_rev_next, best_fwd_reg, best_fwd_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [POS_W-1:0]  best_pos_reg, best_pos_next;
    logic              any_valid_reg, any_valid_next;
    logic [4:0]        step_reg, step_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] nx_reg, nx_next;
    logic [5:0]        e_reg, e_next;
    logic [DATA_W-1:0] y_reg, y_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              phase_reg, phase_next;
    logic [LOG_W-1:0]  lr_reg, lr_next, lf_reg, lf_next;
    logic [DB_W-1:0]   db_reg, db_next;
    logic [HZ_W-1:0]   hz_reg, hz_next;
    logic              m_valid_reg, m_valid_next;
    logic [79:0]       m_data_reg, m_data_next;
    logic              m_found_reg, m_found_next;

    logic [DATA_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [IDX_W-1:0]  div_rem;

    logic              pt_valid;
    logic              pr_small;
    logic [3:0]        prev_step;
    logic [ACC_W-1:0]  term;
    logic [LOG_W:0]    dlog;
    logic              dneg;
    logic [LOG_W:0]    dmag;
    logic [56:0]       db_rnd;
    logic [DB_W-1:0]   db_q;
    logic [33:0]       span;
    logic              span_neg;
    logic [HZ_W-1:0]   span_mag;
    logic [49:0]       q_adj;
    logic [50:0]       f_sum;
    logic [HZ_W-1:0]   f_clamp;
    logic [32:0]       sq;
    logic [IDX_W-1:0]  in_idx;

    rms_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    rms_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (points_reg - 16'd1),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= START_RESET;
            stop_reg   <= STOP_RESET;
            points_reg <= POINTS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SWEEP_START:  start_reg  <= cfg_wdata;
                CFG_SWEEP_STOP:   stop_reg   <= cfg_wdata;
                CFG_SWEEP_POINTS: points_reg <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_idx   = s_tdata[143:128];
    assign pr_small = (pr_reg[63:4] == '0) && (pr_reg[3:0] < 4'd10);
    assign pt_valid = (pf_reg != '0) && (!pr_small || (pf_reg < e18_times(pr_reg[3:0])));

    // cross-product partial term, accumulated in the cycle after its issue
    assign prev_step = step_reg[3:0] - 4'd1;
    always_comb begin
        unique case (prev_step[1:0])
            2'd0:    term = ACC_W'(prod);
            2'd3:    term = ACC_W'(prod) << 64;
            default: term = ACC_W'(prod) << 32;
        endcase
        if (prev_step[2])
            term = ~term + 1'b1;
    end

    assign dlog   = {1'b0, lr_reg} - {1'b0, lf_reg};
    assign dneg   = dlog[LOG_W];
    assign dmag   = dneg ? (~dlog + 1'b1) : dlog;
    // round half away from zero: add 2^39 before dropping 40 bits
    assign db_rnd = prod[56:0] + (57'd1 << 39);
    assign db_q   = db_rnd[56:40];

    assign span     = {1'b0, stop_reg} - {1'b0, start_reg};
    assign span_neg = span[33];
    assign span_mag = span_neg ? HZ_W'(~span + 1'b1) : span[HZ_W-1:0];

    assign div_num = NUM_W'(prod[47:0])
                   + (span_mag[32] ? NUM_W'({best_idx_reg, 32'd0}) : '0);
    assign q_adj   = 50'(div_quo) + 50'(span_neg && (div_rem != '0));
    assign f_sum   = span_neg ? (51'(start_reg) - 51'(q_adj))
                              : (51'(start_reg) + 51'(q_adj));
    always_comb begin
        if (f_sum[50])
            f_clamp = '0;
        else if (f_sum[49:33] != '0)
            f_clamp = HZ_MAX;
        else
            f_clamp = f_sum[32:0];
    end

    assign sq = prod[63:31];

    always_comb begin
        state_next     = state_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        pf_next        = pf_reg;
        pr_next        = pr_reg;
        best_rev_next  = best_rev_reg;
        best_fwd_next  = best_fwd_reg;
        best_idx_next  = best_idx_reg;
        best_pos_next  = best_pos_reg;
        any_valid_next = any_valid_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        nx_next        = nx_reg;
        e_next         = e_reg;
        y_next         = y_reg;
        frac_next      = frac_reg;
        phase_next     = phase_reg;
        lr_next        = lr_reg;
        lf_next        = lf_reg;
        db_next        = db_reg;
        hz_next        = hz_reg;
        m_data_next    = m_data_reg;
        m_found_next   = m_found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fa_next   = abs32(s_tdata[31:0]);
                    fb_next   = abs32(s_tdata[63:32]);
                    ra_next   = abs32(s_tdata[95:64]);
                    rb_next   = abs32(s_tdata[127:96]);
                    idx_next  = (in_idx >= points_reg) ? IDX_W'(cnt_reg) : in_idx;
                    last_next = s_tlast;
                    step_next = '0;
                    state_next = ST_POWER;
                end
            end
            ST_POWER: begin
                unique case (step_reg[2:0])
                    3'd0: begin mul_a = fa_reg; mul_b = fa_reg; end
                    3'd1: begin mul_a = fb_reg; mul_b = fb_reg; pf_next = prod; end
                    3'd2: begin mul_a = ra_reg; mul_b = ra_reg; pf_next = pf_reg + prod; end
                    3'd3: begin mul_a = rb_reg; mul_b = rb_reg; pr_next = prod; end
                    default: begin
                        pr_next    = pr_reg + prod;
                        state_next = ST_CHECK;
                    end
                endcase
                step_next = step_reg + 5'd1;
            end
            ST_CHECK: begin
                state_next = ST_WRAP;
                if (pt_valid) begin
                    if (any_valid_reg) begin
                        step_next  = '0;
                        state_next = ST_CMP;
                    end else begin
                        best_rev_next  = pr_reg;
                        best_fwd_next  = pf_reg;
                        best_idx_next  = idx_reg;
                        best_pos_next  = POS_W'(cnt_reg);
                        any_valid_next = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                // steps 0..3: pr * best_fwd, steps 4..7: best_rev * pf
                if (!step_reg[3]) begin
                    mul_a = step_reg[2]
                          ? (step_reg[1] ? best_rev_reg[63:32] : best_rev_reg[31:0])
                          : (step_reg[1] ? pr_reg[63:32] : pr_reg[31:0]);
                    mul_b = step_reg[2]
                          ? (step_reg[0] ? pf_reg[63:32] : pf_reg[31:0])
                          : (step_reg[0] ? best_fwd_reg[63:32] : best_fwd_reg[31:0]);
                end
                if (step_reg == '0)
                    acc_next = '0;
                else
                    acc_next = acc_reg + term;
                if (step_reg[3])
                    state_next = ST_DECIDE;
                step_next = step_reg + 5'd1;
            end
            ST_DECIDE: begin
                if (acc_reg[ACC_W-1]) begin
                    best_rev_next = pr_reg;
                    best_fwd_next = pf_reg;
                    best_idx_next = idx_reg;
                    best_pos_next = POS_W'(cnt_reg);
                end
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                if (!last_reg) begin
                    if (cnt_reg != CNT_W'(MAX_POINTS - 1))
                        cnt_next = cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end else if (any_valid_reg) begin
                    nx_next    = best_rev_reg;
                    e_next     = 6'd63;
                    phase_next = 1'b0;
                    state_next = ST_NORM;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_NORM: begin
                if (nx_reg[63] || (e_reg == '0)) begin
                    y_next     = nx_reg[63:32];
                    step_next  = '0;
                    state_next = ST_LOG_MUL;
                end else begin
                    nx_next = {nx_reg[62:0], 1'b0};
                    e_next  = e_reg - 6'd1;
                end
            end
            ST_LOG_MUL: begin
                mul_a      = y_reg;
                mul_b      = y_reg;
                state_next = ST_LOG_STEP;
            end
            ST_LOG_STEP: begin
                y_next    = sq[32] ? sq[32:1] : sq[31:0];
                frac_next = {frac_reg[FRAC_W-2:0], sq[32]};
                if (step_reg == 5'd23) begin
                    if (!phase_reg) begin
                        lr_next    = {e_reg, frac_next};
                        nx_next    = best_fwd_reg;
                        e_next     = 6'd63;
                        phase_next = 1'b1;
                        state_next = ST_NORM;
                    end else begin
                        lf_next    = {e_reg, frac_next};
                        state_next = ST_DB_MUL;
                    end
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = ST_LOG_MUL;
                end
            end
            ST_DB_MUL: begin
                mul_a      = DATA_W'(dmag);
                mul_b      = DB_CONST;
                state_next = ST_DB_DONE;
            end
            ST_DB_DONE: begin
                db_next    = dneg ? (~db_q + 1'b1) : db_q;
                state_next = ST_HZ_MUL;
            end
            ST_HZ_MUL: begin
                if (points_reg <= 16'd1) begin
                    hz_next    = start_reg;
                    state_next = ST_OUT;
                end else begin
                    mul_a      = DATA_W'(best_idx_reg);
                    mul_b      = span_mag[31:0];
                    state_next = ST_HZ_DIV;
                end
            end
            ST_HZ_DIV: begin
                div_start  = 1'b1;
                state_next = ST_HZ_WAIT;
            end
            ST_HZ_WAIT: begin
                if (div_done) begin
                    hz_next    = f_clamp;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = any_valid_reg;
                    if (any_valid_reg)
                        m_data_next = {6'd0, db_reg, hz_reg, best_idx_reg, best_pos_reg};
                    else
                        m_data_next = '0;
                    cnt_next       = '0;
                    any_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            any_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            any_valid_reg <= any_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        fa_reg       <= fa_next;
        fb_reg       <= fb_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        pf_reg       <= pf_next;
        pr_reg       <= pr_next;
        best_rev_reg <= best_rev_next;
        best_fwd_reg <= best_fwd_next;
        best_idx_reg <= best_idx_next;
        best_pos_reg <= best_pos_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        nx_reg       <= nx_next;
        e_reg        <= e_next;
        y_reg        <= y_next;
        frac_reg     <= frac_next;
        phase_reg    <= phase_next;
        lr_reg       <= lr_next;
        lf_reg       <= lf_next;
        db_reg       <= db_next;
        hz_reg       <= hz_next;
        m_data_reg   <= m_data_next;
        m_found_reg  <= m_found_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

endmodule
